>>> hw/rtl/sactl_pkg.sv
// shared types, sizes and helpers for the set associative tag lookup unit
// no dependencies; imported by sactl_region, sactl_way_logic and the top level
package sactl_pkg;

	localparam int BYTE_OFFSET_BITS = 2;
	localparam int WORD_INDEX_BITS  = 2;
	localparam int SET_INDEX_BITS   = 2;
	localparam int WAYS             = 2;

	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 64;
	localparam int WAY_OUT_W = 3;
	localparam int LOW_BITS  = BYTE_OFFSET_BITS + WORD_INDEX_BITS;
	localparam int TAG_SHIFT = LOW_BITS + SET_INDEX_BITS;
	localparam int TAG_W     = ADDR_W - TAG_SHIFT;
	localparam int SETS      = 1 << SET_INDEX_BITS;
	localparam int SET_AW    = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
	localparam int WAY_AW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W     = WAYS * TAG_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// result word: six flag/way bits below three totals
	localparam int OUT_BITS    = 3 + WAY_OUT_W + 3 * CNT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD     = OUT_TDATA_W - OUT_BITS;

	localparam logic [CFG_DATA_W-1:0] WINDOW_BASE_RST  = 32'h3000_0000;
	localparam logic [CFG_DATA_W-1:0] WINDOW_SIZE_RST  = 32'h0100_0000;
	localparam logic [CFG_DATA_W-1:0] MEMORY_FLOOR_RST = 32'h8000_0000;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [SET_AW-1:0] set_idx_t;
	typedef logic [WAY_AW-1:0] way_idx_t;
	typedef logic [WAYS-1:0]   way_vec_t;
	typedef logic [ROW_W-1:0]  tag_row_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_BASE  = 2'd0,
		REG_WINDOW_SIZE  = 2'd1,
		REG_MEMORY_FLOOR = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		cnt_t                 writebacks_total;
		cnt_t                 misses_total;
		cnt_t                 hits_total;
		logic                 writeback;
		logic [WAY_OUT_W-1:0] way;
		logic                 hit;
		logic                 cachable;
	} lookup_res_t;

	function automatic set_idx_t set_of(addr_t addr);
		return set_idx_t'((addr >> LOW_BITS) & ADDR_W'(SETS - 1));
	endfunction

	function automatic tag_t tag_of(addr_t addr);
		return tag_t'(addr >> TAG_SHIFT);
	endfunction

endpackage

>>> hw/rtl/sactl_tag_ram.sv
// generic simple dual port synchronous ram with a registered read
// no dependencies; holds one row of tags per set
module sactl_tag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW    = 2
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read before write on a shared address; the caller forwards
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/sactl_region.sv
// region configuration registers and the cachable address check
// depends on sactl_pkg
module sactl_region
	import sactl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  addr_t   addr,
	output logic    cachable
);

	logic [CFG_DATA_W-1:0] window_base_q;
	logic [CFG_DATA_W-1:0] window_size_q;
	logic [CFG_DATA_W-1:0] memory_floor_q;
	logic [ADDR_W:0]       window_end;
	logic                  in_window;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q  <= WINDOW_BASE_RST;
			window_size_q  <= WINDOW_SIZE_RST;
			memory_floor_q <= MEMORY_FLOOR_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_WINDOW_BASE:  window_base_q  <= cfg.data;
				REG_WINDOW_SIZE:  window_size_q  <= cfg.data;
				REG_MEMORY_FLOOR: memory_floor_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// window end kept at 33 bits so it never wraps
	always_comb begin
		window_end = {1'b0, window_base_q} + {1'b0, window_size_q};
		in_window  = (addr >= window_base_q) && ({1'b0, addr} < window_end);
		cachable   = in_window || (addr >= memory_floor_q);
	end

endmodule

>>> hw/rtl/sactl_way_logic.sv
// tag compare, nru victim choice, per set state bits and running totals
// depends on sactl_pkg; tag rows come from sactl_tag_ram
module sactl_way_logic
	import sactl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        commit,
	input  logic        cach,
	input  logic        wr,
	input  set_idx_t    set,
	input  tag_t        tag,
	input  tag_row_t    row,
	output lookup_res_t res,
	output logic        tag_we,
	output tag_row_t    tag_wrow
);

	way_vec_t valid_q [SETS];
	way_vec_t used_q  [SETS];
	way_vec_t dirty_q [SETS];
	cnt_t     hit_cnt_q;
	cnt_t     miss_cnt_q;
	cnt_t     wb_cnt_q;

	way_vec_t vld, usd, drt, match;
	way_vec_t sel_oh, valid_nx, used_nx, dirty_nx;
	way_idx_t hit_way, victim, sel;
	logic     hit, wb;
	cnt_t     hits_nx, misses_nx, wbs_nx;

	always_comb begin
		vld     = valid_q[set];
		usd     = used_q[set];
		drt     = dirty_q[set];
		match   = '0;
		hit_way = '0;
		victim  = '0;
		for (int w = 0; w < WAYS; w++) begin
			match[w] = vld[w] && (row[w*TAG_W +: TAG_W] == tag);
			// highest way with a clear used bit wins
			if (!usd[w]) begin
				victim = WAY_AW'(w);
			end
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_AW'(w);
			end
		end
		hit    = |match;
		sel    = hit ? hit_way : victim;
		sel_oh = way_vec_t'(1) << sel;
		wb     = !hit && drt[sel];

		valid_nx = vld | sel_oh;
		used_nx  = usd | sel_oh;
		if (&used_nx) begin
			used_nx = sel_oh;
		end
		dirty_nx      = drt;
		dirty_nx[sel] = hit ? (drt[sel] | wr) : wr;

		tag_wrow                     = row;
		tag_wrow[sel*TAG_W +: TAG_W] = tag;
		tag_we                       = commit && cach && !hit;

		hits_nx   = hit_cnt_q + CNT_W'(cach && hit);
		misses_nx = miss_cnt_q + CNT_W'(cach && !hit);
		wbs_nx    = wb_cnt_q + CNT_W'(cach && wb);

		res.cachable         = cach;
		res.hit              = cach && hit;
		res.way              = cach ? WAY_OUT_W'(sel) : '0;
		res.writeback        = cach && wb;
		res.hits_total       = hits_nx;
		res.misses_total     = misses_nx;
		res.writebacks_total = wbs_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
				used_q[s]  <= '0;
				dirty_q[s] <= '0;
			end
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			wb_cnt_q   <= '0;
		end else if (commit) begin
			hit_cnt_q  <= hits_nx;
			miss_cnt_q <= misses_nx;
			wb_cnt_q   <= wbs_nx;
			if (cach) begin
				valid_q[set] <= valid_nx;
				used_q[set]  <= used_nx;
				dirty_q[set] <= dirty_nx;
			end
		end
	end

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		commit && cach |=> (hit_cnt_q + miss_cnt_q) == $past(hit_cnt_q + miss_cnt_q) + 1)
		else $error("cachable access must count exactly one hit or miss");

	a_way_valid: assert property (@(posedge clk) disable iff (!arst_n)
		commit && cach |=> valid_q[$past(set)][$past(sel)])
		else $error("accessed way not valid after update");

	a_used_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		commit && cach && (WAYS > 1) |=> !(&used_q[$past(set)]))
		else $error("used bits of a set left all set");

endmodule

>>> hw/rtl/set_assoc_cache_tag_lookup_unit.sv
// top level of the set associative tag lookup unit with nru replacement
// depends on sactl_pkg, sactl_region, sactl_tag_ram and sactl_way_logic
//
// usage:
//   s_axis: one word per memory access, address in tdata, store flag in tuser.
//   m_axis: one word per access with cachable, hit, way, writeback and the
//     running hit, miss and writeback totals after that access.
//   cfg: writes window base (0), window size (1) and memory floor (2); other
//     indexes are dropped. cfg_ready is always high; write only while idle.
// path: an access is held in the lookup stage, then its result is registered.
// throughput: one access per cycle while m_axis keeps up. The tag ram is read
//   when an access is taken and written on a cachable miss as its result is
//   registered; the next access to that set gets the written row forwarded.
// reset: valid, used and dirty bits, totals and both word slots clear at once,
//   region registers return to their defaults; no clearing pass is needed.
// stall: a result waits in the output register; one more access is taken and
//   held in the lookup stage, then s_axis_tready drops until m_axis_tready.
module set_assoc_cache_tag_lookup_unit
	import sactl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [ADDR_W-1:0]      s_axis_tdata,   // address
	input  logic                   s_axis_tuser,   // store flag
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// cachable, hit, way[2:0], writeback, hits_total[63:0], misses_total[63:0],
	// writebacks_total[63:0], zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_wr_t     cfg;
	logic        in_cach;
	logic        accept;
	logic        out_free;
	logic        commit;
	set_idx_t    in_set;

	logic        s1_valid_q;
	logic        cach_s1;
	logic        wr_s1;
	set_idx_t    set_s1;
	tag_t        tag_s1;
	logic        fwd_s1;
	tag_row_t    fwd_row_s1;

	tag_row_t    rd_row;
	tag_row_t    row_s1;
	tag_row_t    tag_wrow;
	logic        tag_we;
	lookup_res_t res;

	logic        m_valid_q;
	lookup_res_t m_res_q;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign commit        = s1_valid_q && out_free;
	assign s_axis_tready = !s1_valid_q || commit;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_set        = set_of(s_axis_tdata);
	assign row_s1        = fwd_s1 ? fwd_row_s1 : rd_row;

	sactl_region u_region (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.addr     (s_axis_tdata),
		.cachable (in_cach)
	);

	sactl_tag_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS),
		.AW    (SET_AW)
	) u_tag_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_set),
		.rd_data (rd_row),
		.wr_en   (tag_we),
		.wr_addr (set_s1),
		.wr_data (tag_wrow)
	);

	sactl_way_logic u_way_logic (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.cach     (cach_s1),
		.wr       (wr_s1),
		.set      (set_s1),
		.tag      (tag_s1),
		.row      (row_s1),
		.res      (res),
		.tag_we   (tag_we),
		.tag_wrow (tag_wrow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				// ram returns the old row when the same set is written this edge
				fwd_s1     <= tag_we && (set_s1 == in_set);
			end else if (commit) begin
				s1_valid_q <= 1'b0;
				fwd_s1     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cach_s1    <= in_cach;
			wr_s1      <= s_axis_tuser;
			set_s1     <= in_set;
			tag_s1     <= tag_of(s_axis_tdata);
			fwd_row_s1 <= tag_wrow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{OUT_PAD{1'b0}}, m_res_q};

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> s1_valid_q)
		else $error("forwarded row without an access in the lookup stage");

endmodule

>>> test/sactl_lookup_checker.sv
// checker for the set associative tag lookup unit: watches the access, result and
// register write channels, predicts each result from its own tag, valid, used and
// dirty state, and compares field by field; depends on sactl_pkg only
`timescale 1ns / 1ps

module sactl_lookup_checker
	import sactl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [ADDR_W-1:0]      s_axis_tdata,
	input  logic                   s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     errors,
	output int                     pending
);

	addr_t win_base;
	addr_t win_size;
	addr_t mem_floor;

	tag_t tags    [SETS][WAYS];
	logic line_ok [SETS][WAYS];
	logic used    [SETS][WAYS];
	logic dirty   [SETS][WAYS];
	cnt_t hit_cnt;
	cnt_t miss_cnt;
	cnt_t wb_cnt;

	lookup_res_t results_due[$];
	int          mismatch_count;
	int          due_count;

	assign errors  = mismatch_count;
	assign pending = due_count;

	// looks up one access, updates the line state and totals, returns the result word
	task automatic lookup_access(input addr_t addr, input logic wr, output lookup_res_t res);
		logic [ADDR_W:0] win_end;
		logic            cach;
		logic            hit;
		logic            wb;
		logic            all_used;
		int              way;
		int              victim;
		int              s;
		tag_t            t;
		win_end = {1'b0, win_base} + {1'b0, win_size};
		cach    = ((addr >= win_base) && ({1'b0, addr} < win_end)) || (addr >= mem_floor);
		hit     = 1'b0;
		wb      = 1'b0;
		way     = 0;
		victim  = 0;
		if (cach) begin
			s = int'((addr >> LOW_BITS) % SETS);
			t = tag_t'(addr >> TAG_SHIFT);
			for (int w = 0; w < WAYS; w++) begin
				if (!used[s][w])
					victim = w;
				if (!hit && line_ok[s][w] && tags[s][w] == t) begin
					hit = 1'b1;
					way = w;
				end
			end
			if (hit) begin
				hit_cnt++;
				dirty[s][way] = dirty[s][way] | wr;
			end else begin
				miss_cnt++;
				way = victim;
				if (dirty[s][way]) begin
					wb = 1'b1;
					wb_cnt++;
				end
				tags[s][way]    = t;
				line_ok[s][way] = 1'b1;
				dirty[s][way]   = wr;
			end
			used[s][way] = 1'b1;
			all_used = 1'b1;
			for (int w = 0; w < WAYS; w++)
				all_used = all_used & used[s][w];
			// nru aging: keep only the way just touched
			if (all_used) begin
				for (int w = 0; w < WAYS; w++)
					used[s][w] = 1'b0;
				used[s][way] = 1'b1;
			end
		end
		res                  = '0;
		res.cachable         = cach;
		res.hit              = hit;
		res.way              = WAY_OUT_W'(way);
		res.writeback        = wb;
		res.hits_total       = hit_cnt;
		res.misses_total     = miss_cnt;
		res.writebacks_total = wb_cnt;
	endtask

	task automatic compare_field(input string name, input cnt_t exp_val, input cnt_t act_val);
		if (exp_val !== act_val) begin
			if (mismatch_count < 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_val,
					act_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_res_t got;
		lookup_res_t want;
		if (!arst_n) begin
			win_base  = WINDOW_BASE_RST;
			win_size  = WINDOW_SIZE_RST;
			mem_floor = MEMORY_FLOOR_RST;
			for (int s = 0; s < SETS; s++) begin
				for (int w = 0; w < WAYS; w++) begin
					tags[s][w]    = '0;
					line_ok[s][w] = 1'b0;
					used[s][w]    = 1'b0;
					dirty[s][w]   = 1'b0;
				end
			end
			hit_cnt  = '0;
			miss_cnt = '0;
			wb_cnt   = '0;
			results_due.delete();
			mismatch_count = 0;
		end else begin
			// a result word always leaves after its access was taken, so pop first
			if (m_axis_tvalid && m_axis_tready) begin
				got = lookup_res_t'(m_axis_tdata[OUT_BITS-1:0]);
				if (results_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result word with nothing outstanding: %h", $realtime,
							got);
					mismatch_count++;
				end else begin
					want = results_due.pop_front();
					compare_field("cachable", cnt_t'(want.cachable), cnt_t'(got.cachable));
					compare_field("hit", cnt_t'(want.hit), cnt_t'(got.hit));
					compare_field("way", cnt_t'(want.way), cnt_t'(got.way));
					compare_field("writeback", cnt_t'(want.writeback), cnt_t'(got.writeback));
					compare_field("hits_total", want.hits_total, got.hits_total);
					compare_field("misses_total", want.misses_total, got.misses_total);
					compare_field("writebacks_total", want.writebacks_total,
						got.writebacks_total);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_WINDOW_BASE:  win_base  = cfg_data;
					REG_WINDOW_SIZE:  win_size  = cfg_data;
					REG_MEMORY_FLOOR: mem_floor = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				lookup_access(s_axis_tdata, s_axis_tuser, want);
				results_due.push_back(want);
			end
		end
		due_count = results_due.size();
	end

endmodule

>>> test/tb.sv
// testbench top for set_assoc_cache_tag_lookup_unit: resets once, programs the region
// registers phase by phase and streams directed and random accesses with bursty
// input and stalling output; checking is left to sactl_lookup_checker
`timescale 1ns / 1ps

module tb;
	import sactl_pkg::*;

	// index past the register file, must be dropped by the block
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 205;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [ADDR_W-1:0]      s_axis_tdata  = '0;
	logic                   s_axis_tuser  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	int                     errors;
	int                     pending;

	addr_t cur_base  = WINDOW_BASE_RST;
	addr_t cur_size  = WINDOW_SIZE_RST;
	addr_t cur_floor = MEMORY_FLOOR_RST;
	int    burst_left = 0;
	int    ready_mode = 0;
	int    ready_left = 0;
	int    ready_tick = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	set_assoc_cache_tag_lookup_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	sactl_lookup_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	// output side: stall pattern switches between full speed, coin flip, mostly
	// stalled and a fixed 3-of-5 duty cycle
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(20, 300);
		end
		ready_left--;
		ready_tick++;
		case (ready_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= 1'($urandom_range(0, 1));
			2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
			default: m_axis_tready <= (ready_tick % 5) < 3;
		endcase
	end

	task automatic send_access(input addr_t addr, input logic wr);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= addr;
		s_axis_tuser  <= wr;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop sending, wait for every outstanding word, then cover the pipeline latency
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input addr_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (cfg_reg_t'(idx))
			REG_WINDOW_BASE:  cur_base  = value;
			REG_WINDOW_SIZE:  cur_size  = value;
			REG_MEMORY_FLOOR: cur_floor = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// mostly a small pool of tags per set near the region starts, so lines get hit,
	// aged and evicted; the rest is fully random or around the region edges
	function automatic addr_t rand_address();
		addr_t pool_off;
		pool_off = (addr_t'($urandom_range(0, 4)) << TAG_SHIFT)
			| (addr_t'($urandom_range(0, SETS - 1)) << LOW_BITS)
			| addr_t'($urandom_range(0, (1 << LOW_BITS) - 1));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return cur_base + pool_off;
			4, 5, 6:    return cur_floor + pool_off;
			7:          return addr_t'($urandom);
			8:          return cur_base + cur_size + addr_t'($urandom_range(0, 7)) - 4;
			default:    return cur_floor + addr_t'($urandom_range(0, 7)) - 4;
		endcase
	endfunction

	task automatic program_phase(input int phase);
		case (phase)
			0: begin
				// window runs past the top of the address space
				write_reg(REG_WINDOW_BASE, 32'hFFFF_F000);
				write_reg(REG_WINDOW_SIZE, 32'hFFFF_FFFF);
				write_reg(REG_MEMORY_FLOOR, 32'hFFFF_FFFF);
			end
			1: begin
				// empty window, everything cachable
				write_reg(REG_WINDOW_BASE, 32'h0000_0000);
				write_reg(REG_WINDOW_SIZE, 32'h0000_0000);
				write_reg(REG_MEMORY_FLOOR, 32'h0000_0000);
			end
			2: begin
				write_reg(REG_WINDOW_BASE, WINDOW_BASE_RST);
				write_reg(REG_WINDOW_SIZE, WINDOW_SIZE_RST);
				write_reg(REG_MEMORY_FLOOR, MEMORY_FLOOR_RST);
				write_reg(REG_SPARE, addr_t'($urandom));
			end
			3: begin
				write_reg(REG_WINDOW_BASE, 32'h1000_0000);
				write_reg(REG_WINDOW_SIZE, 32'h0000_2000);
				write_reg(REG_MEMORY_FLOOR, 32'hC000_0000);
			end
			default: begin
				write_reg(REG_WINDOW_BASE, addr_t'($urandom));
				write_reg(REG_WINDOW_SIZE, addr_t'($urandom) >> $urandom_range(0, 31));
				write_reg(REG_MEMORY_FLOOR, addr_t'($urandom));
				write_reg(REG_SPARE, addr_t'($urandom));
			end
		endcase
	endtask

	initial begin
		static addr_t dir_addr[16] = '{
			32'h8000_0000, 32'h8000_0000, 32'h8000_0040, 32'h8000_0080,
			32'h8000_0040, 32'h8000_00C0, 32'h0000_0000, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h2FFF_FFFF, 32'h3000_0000, 32'h30FF_FFFF,
			32'h3100_0000, 32'h7FFF_FFFF, 32'h3000_0004, 32'h3000_0000
		};
		static logic dir_wr[16] = '{
			1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
			1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1
		};
		addr_t edges[8];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// store then read hit keeps dirty, nru victim choice, dirty eviction,
		// flash window and memory floor boundaries under the reset settings
		foreach (dir_addr[k])
			send_access(dir_addr[k], dir_wr[k]);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			program_phase(phase);
			edges = '{cur_base - 1, cur_base, cur_base + cur_size - 1, cur_base + cur_size,
				cur_floor - 1, cur_floor, 32'h0000_0000, 32'hFFFF_FFFF};
			foreach (edges[k])
				send_access(edges[k], 1'($urandom_range(0, 1)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					drain();
				send_access(rand_address(), 1'($urandom_range(0, 1)));
			end
		end
		drain();

		if (errors == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/sactl_pkg.sv
hw/rtl/sactl_tag_ram.sv
hw/rtl/sactl_region.sv
hw/rtl/sactl_way_logic.sv
hw/rtl/set_assoc_cache_tag_lookup_unit.sv
test/sactl_lookup_checker.sv
test/tb.sv
